// ===== hw/rtl/sffp_pkg.sv =====
package sffp_pkg;

  localparam int unsigned DIM_W    = 13;
  localparam int unsigned X_W      = 12;
  localparam int unsigned Y_W      = 18;
  localparam int unsigned STATUS_W = 2;

  // atlas width register is clamped to this before use
  localparam logic [DIM_W-1:0] MAX_DIM       = 13'd4096;
  localparam logic [DIM_W-1:0] ATLAS_W_RESET = 13'd1024;
  localparam logic [Y_W:0]     HEIGHT_LIMIT  = 19'd262143;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_SIZE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

  typedef enum logic [1:0] {
    KIND_BAD,
    KIND_HIT,
    KIND_NEW
  } res_kind_e;

  typedef struct packed {
    logic [Y_W-1:0]   top;
    logic [DIM_W-1:0] tall;
    logic [DIM_W-1:0] fill;
  } row_t;

  typedef struct packed {
    logic      load;
    logic      rd_en;
    logic      commit;
    res_kind_e kind;
  } cmd_t;

  typedef struct packed {
    logic bad_size;
    logic issue_more;
    logic hit;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/sffp_req_if.sv =====
interface sffp_req_if;
  logic                           valid;
  logic                           ready;
  logic [sffp_pkg::DIM_W-1:0]     req_width;
  logic [sffp_pkg::DIM_W-1:0]     req_height;

  modport source (output valid, output req_width, output req_height, input ready);
  modport sink (input valid, input req_width, input req_height, output ready);
endinterface

// ===== hw/rtl/sffp_res_if.sv =====
interface sffp_res_if;
  logic                           valid;
  logic                           ready;
  logic                           placed;
  logic [sffp_pkg::X_W-1:0]       pos_x;
  logic [sffp_pkg::Y_W-1:0]       pos_y;
  logic [sffp_pkg::STATUS_W-1:0]  status;
  logic                           opened_row;
  logic [sffp_pkg::Y_W-1:0]       total_height;

  modport source (output valid, output placed, output pos_x, output pos_y, output status,
                  output opened_row, output total_height, input ready);
  modport sink (input valid, input placed, input pos_x, input pos_y, input status,
                input opened_row, input total_height, output ready);
endinterface

// ===== hw/rtl/sffp_cfg_if.sv =====
interface sffp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sffp_pkg::DIM_W-1:0]     atlas_width;

  modport source (output valid, output atlas_width, input ready);
  modport sink (input valid, input atlas_width, output ready);
endinterface

// ===== hw/rtl/shelf_first_fit_placer.sv =====
// channel   dir  signals                                        moves
// req_i     in   valid ready req_width req_height              one placement request
// res_o     out  valid ready placed pos_x pos_y status         one result per request
//                opened_row total_height
// cfg_i     in   valid ready atlas_width                        atlas width register write
//
// A request passes through accept, size check, a scan that compares one row per
// cycle through the registered row-table read port, and commit.
// With no fit every open row is compared; a hit at row k ends the scan at that row.
// Reset clears the row count and used height; row entries need no clearing.
// The result register lets the next request be accepted while a result waits; a commit
// stalls only while that register is still full and not being taken.
module shelf_first_fit_placer #(
  parameter int unsigned MAX_ROWS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sffp_req_if.sink    req_i,
  sffp_res_if.source  res_o,
  sffp_cfg_if.sink    cfg_i
);

  sffp_pkg::cmd_t cmd;
  sffp_pkg::sts_t sts;
  logic           req_ready;

  assign req_i.ready = req_ready;

  sffp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sffp_dpath #(
    .MAX_ROWS (MAX_ROWS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_width_i  (req_i.req_width),
    .req_height_i (req_i.req_height),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg          (cfg_i),
    .res          (res_o)
  );

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while another is in flight");

  // a commit never overwrites a result that is still waiting
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> sts.out_free)
    else $error("commit while result register busy");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> res_o.valid)
    else $error("committed result not presented");

  // no read is issued outside a scan that still has rows left
  a_read_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_en |-> (sts.issue_more && !cmd.load && !cmd.commit))
    else $error("row read outside scan");

endmodule

// ===== hw/rtl/sffp_ctrl.sv =====
module sffp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  sffp_pkg::sts_t sts_i,
  output sffp_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_COMMIT
  } state_e;

  state_e              state_q;
  sffp_pkg::res_kind_e kind_q;

  always_comb begin
    req_ready_o  = 1'b0;
    cmd_o.load   = 1'b0;
    cmd_o.rd_en  = 1'b0;
    cmd_o.commit = 1'b0;
    cmd_o.kind   = kind_q;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
      end
      ST_SCAN: begin
        cmd_o.rd_en = sts_i.issue_more && !sts_i.hit;
      end
      ST_COMMIT: begin
        cmd_o.commit = sts_i.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= sffp_pkg::KIND_BAD;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (req_valid_i) state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          if (sts_i.bad_size) begin
            kind_q  <= sffp_pkg::KIND_BAD;
            state_q <= ST_COMMIT;
          end else begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // the last row read is being compared when no more rows are left to issue
          if (sts_i.hit) begin
            kind_q  <= sffp_pkg::KIND_HIT;
            state_q <= ST_COMMIT;
          end else if (!sts_i.issue_more) begin
            kind_q  <= sffp_pkg::KIND_NEW;
            state_q <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (sts_i.out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/sffp_dpath.sv =====
module sffp_dpath #(
  parameter int unsigned MAX_ROWS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [sffp_pkg::DIM_W-1:0]   req_width_i,
  input  logic [sffp_pkg::DIM_W-1:0]   req_height_i,
  input  sffp_pkg::cmd_t               cmd_i,
  output sffp_pkg::sts_t               sts_o,
  sffp_cfg_if.sink                     cfg,
  sffp_res_if.source                   res
);

  localparam int unsigned CW = $clog2(MAX_ROWS + 1);
  localparam int unsigned IW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  sffp_pkg::row_t                  mem [MAX_ROWS];
  sffp_pkg::row_t                  rd_data_q;
  logic                            rd_vld_q;
  logic [IW-1:0]                   cmp_idx_q;
  logic [CW-1:0]                   scan_idx_q;
  logic [CW-1:0]                   rows_open_q;
  logic [sffp_pkg::Y_W-1:0]        used_q;
  logic [sffp_pkg::DIM_W-1:0]      atlas_w_q;
  logic [sffp_pkg::DIM_W-1:0]      w_q;
  logic [sffp_pkg::DIM_W-1:0]      h_q;

  logic                            out_valid_q;
  logic                            placed_q;
  logic [sffp_pkg::X_W-1:0]        pos_x_q;
  logic [sffp_pkg::Y_W-1:0]        pos_y_q;
  logic [sffp_pkg::STATUS_W-1:0]   status_q;
  logic                            opened_q;
  logic [sffp_pkg::Y_W-1:0]        total_q;

  logic [sffp_pkg::DIM_W-1:0]      aw;
  logic [sffp_pkg::DIM_W:0]        fill_sum;
  logic [sffp_pkg::Y_W:0]          height_sum;
  logic                            full;
  logic                            we;
  logic [IW-1:0]                   wa;
  sffp_pkg::row_t                  wd;

  assign aw         = (atlas_w_q > sffp_pkg::MAX_DIM) ? sffp_pkg::MAX_DIM : atlas_w_q;
  assign fill_sum   = {1'b0, rd_data_q.fill} + {1'b0, w_q};
  assign height_sum = {1'b0, used_q} + {{(sffp_pkg::Y_W + 1 - sffp_pkg::DIM_W){1'b0}}, h_q};
  assign full       = (rows_open_q == CW'(MAX_ROWS)) || (height_sum > sffp_pkg::HEIGHT_LIMIT);

  assign sts_o.bad_size   = (w_q == '0) || (h_q == '0) || (w_q > aw);
  assign sts_o.issue_more = scan_idx_q < rows_open_q;
  assign sts_o.hit        = rd_vld_q && (h_q <= rd_data_q.tall) && (fill_sum <= {1'b0, aw});
  assign sts_o.out_free   = !out_valid_q || res.ready;

  assign cfg.ready = 1'b1;

  // rd_data_q and cmp_idx_q hold the hit row until commit: no read is issued after a hit
  always_comb begin
    we = 1'b0;
    wa = cmp_idx_q;
    wd = rd_data_q;
    if (cmd_i.commit) begin
      if (cmd_i.kind == sffp_pkg::KIND_HIT) begin
        we      = 1'b1;
        wd.fill = fill_sum[sffp_pkg::DIM_W-1:0];
      end else if (cmd_i.kind == sffp_pkg::KIND_NEW && !full) begin
        we      = 1'b1;
        wa      = rows_open_q[IW-1:0];
        wd.top  = used_q;
        wd.tall = h_q;
        wd.fill = w_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[scan_idx_q[IW-1:0]];
      cmp_idx_q <= scan_idx_q[IW-1:0];
    end
    if (cmd_i.load) begin
      w_q <= req_width_i;
      h_q <= req_height_i;
    end
    if (cmd_i.commit) begin
      placed_q <= 1'b0;
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      opened_q <= 1'b0;
      total_q  <= used_q;
      case (cmd_i.kind)
        sffp_pkg::KIND_HIT: begin
          placed_q <= 1'b1;
          pos_x_q  <= rd_data_q.fill[sffp_pkg::X_W-1:0];
          pos_y_q  <= rd_data_q.top;
          status_q <= sffp_pkg::STATUS_OK;
        end
        sffp_pkg::KIND_NEW: begin
          if (full) begin
            status_q <= sffp_pkg::STATUS_FULL;
          end else begin
            placed_q <= 1'b1;
            pos_y_q  <= used_q;
            opened_q <= 1'b1;
            total_q  <= height_sum[sffp_pkg::Y_W-1:0];
            status_q <= sffp_pkg::STATUS_OK;
          end
        end
        default: status_q <= sffp_pkg::STATUS_BAD_SIZE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q    <= 1'b0;
      scan_idx_q  <= '0;
      rows_open_q <= '0;
      used_q      <= '0;
      atlas_w_q   <= sffp_pkg::ATLAS_W_RESET;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      if (cfg.valid) atlas_w_q <= cfg.atlas_width;
      if (cmd_i.load) begin
        scan_idx_q <= '0;
      end else if (cmd_i.rd_en) begin
        scan_idx_q <= scan_idx_q + 1'b1;
      end
      if (cmd_i.commit && cmd_i.kind == sffp_pkg::KIND_NEW && !full) begin
        rows_open_q <= rows_open_q + 1'b1;
        used_q      <= height_sum[sffp_pkg::Y_W-1:0];
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (res.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res.valid        = out_valid_q;
  assign res.placed       = placed_q;
  assign res.pos_x        = pos_x_q;
  assign res.pos_y        = pos_y_q;
  assign res.status       = status_q;
  assign res.opened_row   = opened_q;
  assign res.total_height = total_q;

endmodule
